// File: src/eab_pkg.sv
// eab_pkg: shared types, constants and arctangent table for the
// euler-angle basis vector block. no dependencies.
`default_nettype none
package eab_pkg;
    localparam int TableLen = 24;
    localparam int AngW = 18;
    localparam int QW = 32;
    localparam int OutW = 16;
    localparam int ZW = 24;
    localparam logic signed [QW-1:0] GainQ30 = 32'sd652032874;
    localparam logic signed [AngW:0] TurnUnits = 19'sd92160;
    localparam logic signed [AngW:0] HalfTurn = 19'sd46080;
    localparam logic signed [AngW:0] QuarterTurn = 19'sd23040;

    typedef logic signed [QW-1:0] t_q30;
    typedef logic signed [OutW-1:0] t_q15;

    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic                 neg;
    } t_fold;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0: v = 24'sd2949120;
            5'd1: v = 24'sd1740967;
            5'd2: v = 24'sd919879;
            5'd3: v = 24'sd466945;
            5'd4: v = 24'sd234379;
            5'd5: v = 24'sd117304;
            5'd6: v = 24'sd58666;
            5'd7: v = 24'sd29335;
            5'd8: v = 24'sd14668;
            5'd9: v = 24'sd7334;
            5'd10: v = 24'sd3667;
            5'd11: v = 24'sd1833;
            5'd12: v = 24'sd917;
            5'd13: v = 24'sd458;
            5'd14: v = 24'sd229;
            5'd15: v = 24'sd115;
            5'd16: v = 24'sd57;
            5'd17: v = 24'sd29;
            5'd18: v = 24'sd14;
            5'd19: v = 24'sd7;
            5'd20: v = 24'sd4;
            5'd21: v = 24'sd2;
            5'd22: v = 24'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // rounded q30 product, floor shift
    function automatic t_q30 mul_q30(input t_q30 a, input t_q30 b);
        logic signed [2*QW-1:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return t_q30'(p >>> 30);
    endfunction

    function automatic t_q15 to_q15(input logic signed [QW+1:0] v);
        logic signed [QW+1:0] r;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767) return 16'sh7fff;
        if (r < -34'sd32768) return 16'sh8000;
        return t_q15'(r);
    endfunction
endpackage
`default_nettype wire

// File: src/eab_lane.sv
// eab_lane: one angle lane; reduces the angle and runs a pipelined cordic.
// depends on eab_pkg.
`default_nettype none
module eab_lane
    import eab_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  wire              i_clk,
    input  wire              i_en,
    input  wire [AngW-1:0]   i_angle,
    output t_q30             o_sin,
    output t_q30             o_cos
);
    localparam int NS = (STEPS > TableLen) ? TableLen : STEPS;

    t_fold fold;
    logic signed [AngW:0] a, m;
    t_q30 r_x [NS+1];
    t_q30 r_y [NS+1];
    logic signed [ZW-1:0] r_z [NS+1];
    logic r_neg [NS+1];

    // modulo via compare/subtract: |a| <= 2^17 < 2*92160
    always_comb begin
        a = {i_angle[AngW-1], i_angle};
        m = a;
        if (m < 0) m = m + TurnUnits;
        if (m >= TurnUnits) m = m - TurnUnits;
        if (m > HalfTurn) m = m - TurnUnits;
        fold.neg = 1'b0;
        if (m > QuarterTurn) begin
            m = m - HalfTurn;
            fold.neg = 1'b1;
        end else if (m < -QuarterTurn) begin
            m = m + HalfTurn;
            fold.neg = 1'b1;
        end
        fold.z = ZW'(m) <<< 8;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= GainQ30;
            r_y[0] <= '0;
            r_z[0] <= fold.z;
            r_neg[0] <= fold.neg;
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[g+1] <= r_neg[g];
                if (!r_z[g][ZW-1]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_q16(5'(g));
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_q16(5'(g));
                end
            end
        end
    end

    assign o_sin = r_neg[NS] ? -r_y[NS] : r_y[NS];
    assign o_cos = r_neg[NS] ? -r_x[NS] : r_x[NS];
endmodule
`default_nettype wire

// File: src/eab_merge.sv
// eab_merge: combines the three lanes' sine/cosine into nine q1.15 outputs
// over three registered product stages. depends on eab_pkg.
`default_nettype none
module eab_merge
    import eab_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_en,
    input  t_q30  i_sp, i_cp, i_sy, i_cy, i_sr, i_cr,
    output t_q15  o_v [9]
);
    t_q30 r1_sp, r1_cp, r1_sy, r1_cy, r1_sr, r1_cr, r1_srsp, r1_crsp;
    t_q30 r2 [12];
    t_q30 r2_sp;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sp <= i_sp; r1_cp <= i_cp; r1_sy <= i_sy;
            r1_cy <= i_cy; r1_sr <= i_sr; r1_cr <= i_cr;
            r1_srsp <= mul_q30(i_sr, i_sp);
            r1_crsp <= mul_q30(i_cr, i_sp);
            r2_sp <= r1_sp;
            r2[0] <= mul_q30(r1_cp, r1_cy);
            r2[1] <= mul_q30(r1_cp, r1_sy);
            r2[2] <= mul_q30(r1_srsp, r1_cy);
            r2[3] <= mul_q30(r1_cr, r1_sy);
            r2[4] <= mul_q30(r1_srsp, r1_sy);
            r2[5] <= mul_q30(r1_cr, r1_cy);
            r2[6] <= mul_q30(r1_sr, r1_cp);
            r2[7] <= mul_q30(r1_crsp, r1_cy);
            r2[8] <= mul_q30(r1_sr, r1_sy);
            r2[9] <= mul_q30(r1_crsp, r1_sy);
            r2[10] <= mul_q30(r1_sr, r1_cy);
            r2[11] <= mul_q30(r1_cr, r1_cp);
            o_v[0] <= to_q15(34'(r2[0]));
            o_v[1] <= to_q15(34'(r2[1]));
            o_v[2] <= to_q15(-34'(r2_sp));
            o_v[3] <= to_q15(34'(r2[3]) - 34'(r2[2]));
            o_v[4] <= to_q15(-34'(r2[4]) - 34'(r2[5]));
            o_v[5] <= to_q15(-34'(r2[6]));
            o_v[6] <= to_q15(34'(r2[7]) + 34'(r2[8]));
            o_v[7] <= to_q15(34'(r2[9]) - 34'(r2[10]));
            o_v[8] <= to_q15(34'(r2[11]));
        end
    end
endmodule
`default_nettype wire

// File: src/euler_angles_to_basis_vectors.sv
// channel | handshake            | payload
// in      | i_valid / o_ready    | i_pitch_angle, i_yaw_angle, i_roll_angle
// out     | o_valid / i_ready    | o_forward_*, o_right_*, o_up_*
// one item per cycle while not stalled; o_valid rises once the accepted item has passed
// the fold register, one stage per cordic iteration (CORDIC_STEPS, capped at 24) and
// three product/rounding stages. the whole pipeline advances when the output
// register is empty or taken; a stall freezes every stage.
// reset clears only the stage valid bits.
`default_nettype none
module euler_angles_to_basis_vectors
    import eab_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire signed [AngW-1:0]   i_pitch_angle,
    input  wire signed [AngW-1:0]   i_yaw_angle,
    input  wire signed [AngW-1:0]   i_roll_angle,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic signed [OutW-1:0]  o_forward_x,
    output logic signed [OutW-1:0]  o_forward_y,
    output logic signed [OutW-1:0]  o_forward_z,
    output logic signed [OutW-1:0]  o_right_x,
    output logic signed [OutW-1:0]  o_right_y,
    output logic signed [OutW-1:0]  o_right_z,
    output logic signed [OutW-1:0]  o_up_x,
    output logic signed [OutW-1:0]  o_up_y,
    output logic signed [OutW-1:0]  o_up_z
);
    localparam int NS = (CORDIC_STEPS > TableLen) ? TableLen : CORDIC_STEPS;
    localparam int Lat = NS + 4;

    logic en;
    logic [Lat-1:0] r_vld;
    t_q30 sp, cp, sy, cy, sr, cr;
    t_q15 v [9];

    assign en = !r_vld[Lat-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[Lat-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Lat-2:0], i_valid};
        end
    end

    eab_lane #(.STEPS(NS)) u_pitch (.i_clk, .i_en(en),
        .i_angle(i_pitch_angle), .o_sin(sp), .o_cos(cp));
    eab_lane #(.STEPS(NS)) u_yaw (.i_clk, .i_en(en),
        .i_angle(i_yaw_angle), .o_sin(sy), .o_cos(cy));
    eab_lane #(.STEPS(NS)) u_roll (.i_clk, .i_en(en),
        .i_angle(i_roll_angle), .o_sin(sr), .o_cos(cr));

    eab_merge u_merge (.i_clk, .i_en(en), .i_sp(sp), .i_cp(cp), .i_sy(sy),
        .i_cy(cy), .i_sr(sr), .i_cr(cr), .o_v(v));

    assign o_forward_x = v[0];
    assign o_forward_y = v[1];
    assign o_forward_z = v[2];
    assign o_right_x = v[3];
    assign o_right_y = v[4];
    assign o_right_z = v[5];
    assign o_up_x = v[6];
    assign o_up_y = v[7];
    assign o_up_z = v[8];

`ifndef NO_ASSERTIONS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_forward_x) && $stable(o_up_z)))
        else $error("output changed while stalled");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready with empty output");
    a_pipe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted item lost in first stage");
`endif
endmodule
`default_nettype wire
